@@ src/line_follow_pid_steering_defines.svh @@
// Assertion macros for the steering block; clk and arst_n are taken from the enclosing module.
`ifndef LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_DEFINES_SVH

// same-cycle implication
`define LFPS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lfps_pkg.sv @@
package lfps_pkg;

	localparam int SensorCount = 5;
	localparam int ReadingW    = 10;
	localparam int IdxW        = $clog2(SensorCount);
	localparam int SumW        = ReadingW + $clog2(SensorCount);
	localparam int WsumW       = SumW + $clog2(SensorCount);
	localparam int DenW        = WsumW;
	localparam int FracW       = 16;
	localparam int DivW        = WsumW + FracW;
	localparam int QuotW       = FracW + 1;
	localparam int DivCntW     = $clog2(QuotW);

	localparam int PosW   = 16;
	localparam int GainW  = 16;
	localparam int SpeedW = 15;
	localparam int IntW   = 32;
	localparam int MulAW  = IntW + 1;
	localparam int MulBW  = GainW + 1;
	localparam int ProdW  = MulAW + MulBW;
	localparam int AccW   = ProdW + 2;
	localparam int CtrlW  = AccW - 8;

	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 16;

	localparam logic [ReadingW-1:0] NoiseRst  = ReadingW'(100);
	localparam logic [ReadingW-1:0] DetectRst = ReadingW'(300);
	localparam logic [ReadingW-1:0] StopRst   = ReadingW'(700);
	localparam logic [GainW-1:0]    GainPRst  = GainW'(256);
	localparam logic [GainW-1:0]    GainIRst  = GainW'(128);
	localparam logic [GainW-1:0]    GainDRst  = GainW'(896);
	localparam logic [SpeedW-1:0]   BaseRst   = SpeedW'(9830);
	localparam logic [SpeedW-1:0]   LimitRst  = SpeedW'(9830);

	localparam logic signed [PosW-1:0] PosMax = 16'sh7FFF;
	localparam logic signed [PosW-1:0] PosMin = 16'sh8000;
	localparam logic signed [IntW-1:0] IntMax = 32'sh7FFF_FFFF;
	localparam logic signed [IntW-1:0] IntMin = 32'sh8000_0000;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_NOISE,
		CFG_DETECT,
		CFG_STOP,
		CFG_GAIN_P,
		CFG_GAIN_I,
		CFG_GAIN_D,
		CFG_BASE,
		CFG_LIMIT
	} cfg_idx_t;

endpackage

@@ src/line_follow_pid_steering.sv @@
// Line follower steering: each item of five reflectance readings yields one result of two
// motor drives, a Q1.15 line position and lost/halted flags. All readings at or above the
// stop threshold latch a halt until reset, after which both drives are zero. The readings
// are scanned one per cycle into two accumulators, a sum and an index-weighted sum, the
// centroid is divided by a serial restoring divider that delivers one quotient bit per
// cycle, and the PID terms go through one shared multiplier, one gain per cycle. in_stall
// is high while an item is worked on; a finished result waits in the output register, and
// the next item is still taken, but its result is held in ST_FINISH until that register
// is free. cfg_ready is always high; write registers only while the block is idle.
`include "line_follow_pid_steering_defines.svh"

module line_follow_pid_steering
	import lfps_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CfgIdxW-1:0]          cfg_index,
	input  logic [CfgDataW-1:0]         cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ReadingW-1:0]         reading_0,
	input  logic [ReadingW-1:0]         reading_1,
	input  logic [ReadingW-1:0]         reading_2,
	input  logic [ReadingW-1:0]         reading_3,
	input  logic [ReadingW-1:0]         reading_4,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [SpeedW-1:0]           drive_left,
	output logic [SpeedW-1:0]           drive_right,
	output logic signed [PosW-1:0]      position,
	output logic                        line_lost,
	output logic                        halted
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIV,
		ST_PREP,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [ReadingW-1:0] noise_q, detect_q, stop_q;
	logic [GainW-1:0]    gain_p_q, gain_i_q, gain_d_q;
	logic [SpeedW-1:0]   base_q, limit_q;

	logic [ReadingW-1:0] rd_q [SensorCount];
	logic [ReadingW-1:0] in_rd [SensorCount];
	logic [IdxW-1:0]     idx_q;
	logic [SumW-1:0]     sum_q;
	logic [WsumW-1:0]    wsum_q;
	logic                seen_q, junc_q;

	logic [DivW-1:0]     num_q, dsh_q;
	logic [QuotW-1:0]    quo_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [DenW-1:0]     den_w;

	logic signed [PosW-1:0] prev_q, pos_q, pos_w, sat_pos_w;
	logic signed [IntW-1:0] integral_q, int_next_w;
	logic signed [IntW:0]   int_sum_w;
	logic signed [PosW:0]   deriv_q;
	logic                   halt_q, lost_q;

	logic [1:0]                mstep_q;
	logic signed [MulAW-1:0]   mul_a;
	logic signed [MulBW-1:0]   mul_b;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    accum_q;
	logic signed [CtrlW-1:0]   ctrl_w;
	logic signed [CtrlW:0]     left_w, right_w;
	logic [SpeedW-1:0]         dl_w, dr_w;

	logic                      out_valid_q, lost_out_q, halted_out_q;
	logic [SpeedW-1:0]         dl_q, dr_q;
	logic signed [PosW-1:0]    pos_out_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);

	assign in_rd[0] = reading_0;
	assign in_rd[1] = reading_1;
	assign in_rd[2] = reading_2;
	assign in_rd[3] = reading_3;
	assign in_rd[4] = reading_4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q  <= NoiseRst;
			detect_q <= DetectRst;
			stop_q   <= StopRst;
			gain_p_q <= GainPRst;
			gain_i_q <= GainIRst;
			gain_d_q <= GainDRst;
			base_q   <= BaseRst;
			limit_q  <= LimitRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NOISE:  noise_q  <= cfg_data[ReadingW-1:0];
				CFG_DETECT: detect_q <= cfg_data[ReadingW-1:0];
				CFG_STOP:   stop_q   <= cfg_data[ReadingW-1:0];
				CFG_GAIN_P: gain_p_q <= cfg_data[GainW-1:0];
				CFG_GAIN_I: gain_i_q <= cfg_data[GainW-1:0];
				CFG_GAIN_D: gain_d_q <= cfg_data[GainW-1:0];
				CFG_BASE:   base_q   <= cfg_data[SpeedW-1:0];
				CFG_LIMIT:  limit_q  <= cfg_data[SpeedW-1:0];
				default: ;
			endcase
		end
	end

	assign den_w = DenW'(sum_q * (SensorCount - 1));

	always_comb begin
		if (quo_q[QuotW-1])
			sat_pos_w = PosMax;
		else
			sat_pos_w = {~quo_q[FracW-1], quo_q[FracW-2:0]};
		pos_w     = lost_q ? pos_q : sat_pos_w;
		int_sum_w = {integral_q[IntW-1], integral_q} + (IntW+1)'(pos_w);
		if (int_sum_w[IntW] != int_sum_w[IntW-1])
			int_next_w = int_sum_w[IntW] ? IntMin : IntMax;
		else
			int_next_w = int_sum_w[IntW-1:0];
	end

	always_comb begin
		case (mstep_q)
			2'd0: begin
				mul_a = MulAW'(pos_q);
				mul_b = {1'b0, gain_p_q};
			end
			2'd1: begin
				mul_a = MulAW'(integral_q);
				mul_b = {1'b0, gain_i_q};
			end
			2'd2: begin
				mul_a = MulAW'(deriv_q);
				mul_b = {1'b0, gain_d_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		ctrl_w  = CtrlW'(accum_q >>> 8);
		left_w  = (CtrlW+1)'($signed({1'b0, base_q})) + (CtrlW+1)'(ctrl_w);
		right_w = (CtrlW+1)'($signed({1'b0, base_q})) - (CtrlW+1)'(ctrl_w);
		if (left_w < 0)
			dl_w = '0;
		else if (left_w > (CtrlW+1)'($signed({1'b0, limit_q})))
			dl_w = limit_q;
		else
			dl_w = left_w[SpeedW-1:0];
		if (right_w < 0)
			dr_w = '0;
		else if (right_w > (CtrlW+1)'($signed({1'b0, limit_q})))
			dr_w = limit_q;
		else
			dr_w = right_w[SpeedW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			halt_q      <= 1'b0;
			prev_q      <= '0;
			integral_q  <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			mstep_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FINISH)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < SensorCount; i++)
							rd_q[i] <= in_rd[i];
						idx_q   <= '0;
						sum_q   <= '0;
						wsum_q  <= '0;
						seen_q  <= 1'b0;
						junc_q  <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					for (int i = 0; i < SensorCount - 1; i++)
						rd_q[i] <= rd_q[i+1];
					if (rd_q[0] < stop_q)
						junc_q <= 1'b0;
					if (rd_q[0] > noise_q) begin
						sum_q  <= sum_q + SumW'(rd_q[0]);
						wsum_q <= wsum_q + WsumW'(rd_q[0]) * WsumW'(idx_q);
						if (rd_q[0] > detect_q)
							seen_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == IdxW'(SensorCount - 1))
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (junc_q || halt_q) begin
						halt_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else if (!seen_q) begin
						pos_q   <= prev_q[PosW-1] ? PosMax : PosMin;
						lost_q  <= 1'b1;
						state_q <= ST_PREP;
					end else begin
						num_q   <= {wsum_q, FracW'(0)};
						dsh_q   <= {den_w, FracW'(0)};
						quo_q   <= '0;
						cnt_q   <= DivCntW'(QuotW - 1);
						lost_q  <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (num_q >= dsh_q) begin
						num_q <= num_q - dsh_q;
						quo_q <= {quo_q[QuotW-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QuotW-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					pos_q      <= pos_w;
					deriv_q    <= (PosW+1)'(pos_w) - (PosW+1)'(prev_q);
					integral_q <= int_next_w;
					prev_q     <= pos_w;
					mstep_q    <= '0;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= mul_a * mul_b;
					mstep_q <= mstep_q + 1'b1;
					case (mstep_q)
						2'd0: ;
						2'd1: accum_q <= AccW'(prod_q);
						2'd2: accum_q <= accum_q + AccW'(prod_q);
						default: begin
							accum_q <= accum_q + AccW'(prod_q);
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (halt_q) begin
							dl_q         <= '0;
							dr_q         <= '0;
							pos_out_q    <= prev_q;
							lost_out_q   <= 1'b0;
							halted_out_q <= 1'b1;
						end else begin
							dl_q         <= dl_w;
							dr_q         <= dr_w;
							pos_out_q    <= pos_q;
							lost_out_q   <= lost_q;
							halted_out_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_left  = dl_q;
	assign drive_right = dr_q;
	assign position    = pos_out_q;
	assign line_lost   = lost_out_q;
	assign halted      = halted_out_q;

	`LFPS_ASSERT_IMPLY(a_halt_drives_zero, out_valid && halted,
		drive_left == '0 && drive_right == '0, "drives not zero while halted")
	`LFPS_ASSERT_IMPLY(a_lost_extreme, out_valid && line_lost,
		position == PosMax || position == PosMin, "lost line position not at an extremum")
	`LFPS_ASSERT_IMPLY(a_lost_not_halted, out_valid && line_lost, !halted,
		"lost and halted together")
	`LFPS_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt latch dropped")

endmodule
